// ----- sv/atq_pkg.sv -----
package atq_pkg;

    localparam int ATQ_MAX_ENTRIES  = 16;
    localparam int ATQ_ADDRESS_BITS = 48;
    localparam int CAP_W            = 5;
    localparam int COUNT_W          = 5;
    localparam int OP_W             = 2;
    localparam int STATUS_W         = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_POP    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_POP_CAP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FRONT_RD,
        ST_REAR_RD,
        ST_REAR_CAP,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_status status;
        logic    found;
        logic    full;
        logic    empty;
    } t_flags;

endpackage

// ----- sv/atq_ram.sv -----
module atq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/atq_ctrl.sv -----
module atq_ctrl
    import atq_pkg::*;
#(
    parameter int MAX_ENTRIES  = ATQ_MAX_ENTRIES,
    parameter int ADDRESS_BITS = ATQ_ADDRESS_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  t_op                     i_op,
    input  logic [ADDRESS_BITS-1:0] i_addr,
    input  logic [CAP_W-1:0]        i_cap,
    input  logic                    i_out_free,
    output logic                    o_ready,
    output logic                    o_done,
    output t_flags                  o_flags,
    output logic [COUNT_W-1:0]      o_count,
    output logic [ADDRESS_BITS-1:0] o_removed,
    output logic [ADDRESS_BITS-1:0] o_front,
    output logic [ADDRESS_BITS-1:0] o_rear
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_idx, n_idx;
    t_status                 r_status, n_status;
    logic                    r_found, n_found;
    logic [ADDRESS_BITS-1:0] r_removed, n_removed;
    logic [ADDRESS_BITS-1:0] r_front, n_front;
    logic [ADDRESS_BITS-1:0] r_rear, n_rear;

    logic                    ram_wr_en;
    logic [IDX_W-1:0]        ram_wr_addr;
    logic [ADDRESS_BITS-1:0] ram_wr_data;
    logic                    ram_rd_en;
    logic [IDX_W-1:0]        ram_rd_addr;
    logic [ADDRESS_BITS-1:0] ram_rd_data;

    logic [CMP_W-1:0] w_cap_ext;
    logic [CMP_W-1:0] w_cap_eff;
    logic             w_full;
    logic             w_cnt_zero;
    logic [CNT_W-1:0] w_idx_next;
    logic [CNT_W-1:0] w_cnt_m1;
    logic             w_last;
    logic             w_more_shift;
    logic             w_match;

    atq_ram #(
        .WIDTH (ADDRESS_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_atq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // capacity above the table depth saturates
    assign w_cap_ext    = CMP_W'(i_cap);
    assign w_cap_eff    = (w_cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : w_cap_ext;
    assign w_full       = CMP_W'(r_count) >= w_cap_eff;
    assign w_cnt_zero   = r_count == '0;
    assign w_idx_next   = CNT_W'(r_idx + 1'b1);
    assign w_cnt_m1     = CNT_W'(r_count - 1'b1);
    assign w_last       = w_idx_next == r_count;
    assign w_more_shift = w_idx_next < r_count;
    assign w_match      = ram_rd_data == r_addr;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_op)
                        OP_INSERT: n_state = ST_FRONT_RD;
                        OP_DELETE, OP_LOOKUP: begin
                            n_state = w_cnt_zero ? ST_FRONT_RD : ST_SCAN_RD;
                        end
                        OP_POP: n_state = w_cnt_zero ? ST_FRONT_RD : ST_POP_CAP;
                        default: n_state = ST_FRONT_RD;
                    endcase
                end
            end
            ST_SCAN_RD: n_state = ST_SCAN_CMP;
            ST_SCAN_CMP: begin
                if (w_match) begin
                    n_state = (r_op == OP_DELETE) ? ST_SHIFT_RD : ST_FRONT_RD;
                end else begin
                    n_state = w_last ? ST_FRONT_RD : ST_SCAN_RD;
                end
            end
            ST_POP_CAP:  n_state = ST_SHIFT_RD;
            ST_SHIFT_RD: n_state = w_more_shift ? ST_SHIFT_WR : ST_FRONT_RD;
            ST_SHIFT_WR: n_state = ST_SHIFT_RD;
            ST_FRONT_RD: n_state = w_cnt_zero ? ST_DONE : ST_REAR_RD;
            ST_REAR_RD:  n_state = ST_REAR_CAP;
            ST_REAR_CAP: n_state = ST_DONE;
            ST_DONE:     n_state = i_out_free ? ST_IDLE : ST_DONE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_op        = r_op;
        n_addr      = r_addr;
        n_count     = r_count;
        n_idx       = r_idx;
        n_status    = r_status;
        n_found     = r_found;
        n_removed   = r_removed;
        n_front     = r_front;
        n_rear      = r_rear;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = r_addr;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_op      = i_op;
                    n_addr    = i_addr;
                    n_status  = STAT_OK;
                    n_found   = 1'b0;
                    n_removed = '0;
                    n_idx     = '0;
                    unique case (i_op)
                        OP_INSERT: begin
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = r_count[IDX_W-1:0];
                                ram_wr_data = i_addr;
                                n_count     = CNT_W'(r_count + 1'b1);
                            end
                        end
                        OP_DELETE, OP_LOOKUP: begin
                            if (w_cnt_zero) begin
                                n_status = STAT_EMPTY;
                            end
                        end
                        OP_POP: begin
                            if (w_cnt_zero) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                ram_rd_en = 1'b1;
                            end
                        end
                        default: n_status = STAT_OK;
                    endcase
                end
            end
            ST_SCAN_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_idx[IDX_W-1:0];
            end
            ST_SCAN_CMP: begin
                if (w_match) begin
                    n_found = 1'b1;
                end else if (w_last) begin
                    n_status = STAT_NOT_FOUND;
                end else begin
                    n_idx = w_idx_next;
                end
            end
            ST_POP_CAP: begin
                n_removed = ram_rd_data;
                n_idx     = '0;
            end
            ST_SHIFT_RD: begin
                if (w_more_shift) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = w_idx_next[IDX_W-1:0];
                end else begin
                    n_count = w_cnt_m1;
                end
            end
            ST_SHIFT_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_idx[IDX_W-1:0];
                ram_wr_data = ram_rd_data;
                n_idx       = w_idx_next;
            end
            ST_FRONT_RD: begin
                if (w_cnt_zero) begin
                    n_front = '0;
                    n_rear  = '0;
                end else begin
                    ram_rd_en = 1'b1;
                end
            end
            ST_REAR_RD: begin
                n_front     = ram_rd_data;
                ram_rd_en   = 1'b1;
                ram_rd_addr = w_cnt_m1[IDX_W-1:0];
            end
            ST_REAR_CAP: n_rear = ram_rd_data;
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_addr    <= n_addr;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_found   <= n_found;
        r_removed <= n_removed;
        r_front   <= n_front;
        r_rear    <= n_rear;
    end

    assign o_ready        = r_state == ST_IDLE;
    assign o_done         = (r_state == ST_DONE) && i_out_free;
    assign o_flags.status = r_status;
    assign o_flags.found  = r_found;
    assign o_flags.full   = w_full;
    assign o_flags.empty  = w_cnt_zero;
    assign o_count        = COUNT_W'(r_count);
    assign o_removed      = r_removed;
    assign o_front        = r_front;
    assign o_rear         = r_rear;

endmodule

// ----- sv/address_table_queue_core.sv -----
// Ordered table of device addresses kept packed from the front, served one word at a time.
// A word on s_axis carries the operation in tuser (insert, delete, lookup, pop) and the
// address in tdata; each one yields exactly one result word on m_axis with status, found,
// the popped address, the entry count, full and empty flags and the front and rear entries.
// The entries sit in a single-port-read RAM walked by a small sequencer with one shared
// address comparator. A lookup or a delete reads and compares the entries in order from
// the front, and a delete with a match moves the entries behind it forward; a pop takes
// the front entry and moves the rest forward, and an insert on a table that is not full
// writes the new address at the rear. Each item ends by reading the front and rear
// entries unless the table is empty, and on an empty table no scan or shift is done.
// A result word held by m_axis_tready low stalls the next finished result in the sequencer.
// s_axis_tready is low while an item is in work. The finished result sits in an
// output register, so the next item is taken while it waits. The capacity register may be
// written whenever no item is in work.
module address_table_queue_core
    import atq_pkg::*;
#(
    parameter int MAX_ENTRIES  = ATQ_MAX_ENTRIES,
    parameter int ADDRESS_BITS = ATQ_ADDRESS_BITS
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_cfg_wr_en,
    input  logic [CAP_W-1:0]                               i_cfg_wr_data,
    input  logic                                           s_axis_tvalid,
    output logic                                           s_axis_tready,
    // address
    input  logic [((ADDRESS_BITS + 7) / 8) * 8 - 1:0]      s_axis_tdata,
    // operation
    input  logic [OP_W-1:0]                                s_axis_tuser,
    output logic                                           m_axis_tvalid,
    input  logic                                           m_axis_tready,
    // status, found, removed_address, entry_count, is_full, is_empty,
    // front_address, rear_address
    output logic [((3 * ADDRESS_BITS + 17) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int OUT_W = ((3 * ADDRESS_BITS + 17) / 8) * 8;

    logic [CAP_W-1:0]        r_cap;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;

    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_done;
    logic                    w_ready;
    t_flags                  w_flags;
    logic [COUNT_W-1:0]      w_count;
    logic [ADDRESS_BITS-1:0] w_removed;
    logic [ADDRESS_BITS-1:0] w_front;
    logic [ADDRESS_BITS-1:0] w_rear;
    logic [OUT_W-1:0]        w_out_word;

    assign w_accept   = s_axis_tvalid && w_ready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    atq_ctrl #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_atq_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_op       (t_op'(s_axis_tuser)),
        .i_addr     (s_axis_tdata[ADDRESS_BITS-1:0]),
        .i_cap      (r_cap),
        .i_out_free (w_out_free),
        .o_ready    (w_ready),
        .o_done     (w_done),
        .o_flags    (w_flags),
        .o_count    (w_count),
        .o_removed  (w_removed),
        .o_front    (w_front),
        .o_rear     (w_rear)
    );

    assign w_out_word = OUT_W'({w_rear, w_front, w_flags.empty, w_flags.full, w_count,
                                w_removed, w_flags.found, w_flags.status});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_data <= w_out_word;
        end
    end

    assign s_axis_tready = w_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- sv/atq_checker.sv -----
module atq_checker
    import atq_pkg::*;
#(
    parameter int ADDRESS_BITS = ATQ_ADDRESS_BITS
) (
    input logic                                           i_clk,
    input logic                                           i_rst_n,
    input logic                                           s_axis_tvalid,
    input logic                                           s_axis_tready,
    input logic                                           m_axis_tvalid,
    input logic                                           m_axis_tready,
    // status, found, removed_address, entry_count, is_full, is_empty,
    // front_address, rear_address
    input logic [((3 * ADDRESS_BITS + 17) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int FOUND_BIT = STATUS_W;
    localparam int CNT_LO    = STATUS_W + 1 + ADDRESS_BITS;
    localparam int EMPTY_BIT = CNT_LO + COUNT_W + 1;
    localparam int FRONT_LO  = EMPTY_BIT + 1;
    localparam int REAR_LO   = FRONT_LO + ADDRESS_BITS;

    logic [STATUS_W-1:0]     w_status;
    logic                    w_found;
    logic [COUNT_W-1:0]      w_count;
    logic                    w_empty;
    logic [ADDRESS_BITS-1:0] w_front;
    logic [ADDRESS_BITS-1:0] w_rear;

    assign w_status = m_axis_tdata[STATUS_W-1:0];
    assign w_found  = m_axis_tdata[FOUND_BIT];
    assign w_count  = m_axis_tdata[CNT_LO +: COUNT_W];
    assign w_empty  = m_axis_tdata[EMPTY_BIT];
    assign w_front  = m_axis_tdata[FRONT_LO +: ADDRESS_BITS];
    assign w_rear   = m_axis_tdata[REAR_LO +: ADDRESS_BITS];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again before the item finished");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_empty |-> w_count == '0)
        else $error("empty flag with nonzero count");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_empty |-> w_front == '0 && w_rear == '0)
        else $error("empty table shows front or rear entry");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status == STAT_EMPTY |-> w_empty && !w_found)
        else $error("empty status on a table with entries");

endmodule

bind address_table_queue_core atq_checker #(
    .ADDRESS_BITS (ADDRESS_BITS)
) u_atq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
